### rtl/cordic_sine_defines.svh
// ----------------------------------------------------------------------------
// cordic_sine_defines : assertion macros
// concurrent check macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_DEFINES_SVH
`define CORDIC_SINE_DEFINES_SVH

`ifndef SYNTH
// check that is skipped while reset is high
`define CDSN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cordic_sine check failed");
// check that also runs during reset
`define CDSN_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cordic_sine reset check failed");
`else
`define CDSN_ASSERT(label, clk, rst, prop)
`define CDSN_ASSERT_RST(label, clk, prop)
`endif

`endif

### rtl/cdsn_pkg.sv
// ----------------------------------------------------------------------------
// cdsn_pkg
// widths, fixed-point constants, stage payload type and arctangent table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdsn_pkg;

  localparam int ANGLE_W    = 32;
  localparam int SINE_W     = 18;
  localparam int ZW         = 32;
  localparam int XYW        = 32;
  localparam int TABLE_LEN  = 24;
  localparam int CDSN_ITERATIONS = 16;
  localparam int OUT_SHIFT  = 14;

  // q28 angles
  localparam logic signed [ZW-1:0] ANG_PI      = 32'sd843314857;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 32'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 32'sd421657428;
  // q30 inverse gain
  localparam logic signed [XYW-1:0] GAIN_INV   = 32'sd652032874;
  localparam logic signed [XYW:0]   ROUND_BIAS = 33'sd8192;
  localparam logic signed [XYW:0]   SINE_MAX   = 33'sd65536;

  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  neg;
  } cdsn_rot_t;

  // atan(2^-i) in q28, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/cordic_sine.sv
// ----------------------------------------------------------------------------
// cordic_sine
// pipelined cordic sine of a q28 radian angle, q16 result
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one angle per transfer (q28 radians, any 32-bit value);
//   m_axis returns its sine (q16, saturated to +-1.0) in the same order.
//   the pipeline has 3 reduction stages, one stage per rotation and
//   1 rounding stage; rotations past 24 are dropped. throughput is one
//   transfer per cycle while m_axis_tready is high, set by the
//   one-rotation-per-stage unrolled pipeline.
//   every stage has its own valid bit and takes new data when it is empty or
//   the next stage moves, so bubbles collapse: with m_axis_tready low the
//   pipeline keeps accepting input until every stage is full, and nothing is
//   lost or repeated when the stall ends.
//   rst (synchronous, active high) empties the pipeline; the block holds no
//   other state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cordic_sine_defines.svh"

module cordic_sine
  import cdsn_pkg::*;
#(
  parameter int ITERATIONS = CDSN_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [17:0] sine, [23:18] zero
);

  // rotations beyond the arctangent table are not performed
  localparam int NUM_STAGES = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  cdsn_rot_t                stage_data  [NUM_STAGES+1];
  logic [NUM_STAGES:0]      stage_valid;
  logic [NUM_STAGES:0]      stage_ready;
  logic signed [SINE_W-1:0] sine;

  // range reduction feeds stage 0 with x = GAIN_INV, y = 0
  cdsn_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .angle     (s_axis_tdata),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  // one rotation per register stage
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rot
    cdsn_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  // rounding, sign restore and saturation; also the output register
  cdsn_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[NUM_STAGES]),
    .in_ready  (stage_ready[NUM_STAGES]),
    .in_data   (stage_data[NUM_STAGES]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sine      (sine)
  );

  assign m_axis_tdata = {{(24-SINE_W){1'b0}}, sine};

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  // reset empties the output stage
  `CDSN_ASSERT_RST(a_rst_empty, clk, rst |=> !m_axis_tvalid)
  // input can only back up when every stage is full and the sink stalls
  `CDSN_ASSERT(a_full_only_on_stall, clk, rst,
               !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
  // folded angle lies within +-pi/2
  `CDSN_ASSERT(a_fold_range, clk, rst,
               stage_valid[0] |-> (stage_data[0].z <= ANG_HALF_PI &&
                                   stage_data[0].z >= -ANG_HALF_PI))
  // result is saturated to +-1.0
  `CDSN_ASSERT(a_sat_range, clk, rst,
               m_axis_tvalid |-> (sine <= SINE_W'(SINE_MAX) &&
                                  sine >= SINE_W'(-SINE_MAX)))

endmodule

### rtl/cdsn_reduce.sv
// ----------------------------------------------------------------------------
// cdsn_reduce
// three-stage angle reduction: modulo 2*pi, wrap to [-pi, pi], fold to +-pi/2
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdsn_reduce
  import cdsn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cdsn_rot_t                 out_data
);

  logic                 va, vb, vc;
  logic                 rdy_a, rdy_b, rdy_c;
  logic signed [ZW-1:0] za, zb, zc;
  logic                 nc;
  logic signed [ZW-1:0] za_next, zb_next, zc_next;
  logic                 nc_next;

  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // truncating remainder, quotient is at most one in magnitude
  always_comb begin
    if (angle >= ANG_TWO_PI) begin
      za_next = angle - ANG_TWO_PI;
    end else if (angle <= -ANG_TWO_PI) begin
      za_next = angle + ANG_TWO_PI;
    end else begin
      za_next = angle;
    end
  end

  always_comb begin
    if (za > ANG_PI) begin
      zb_next = za - ANG_TWO_PI;
    end else if (za < -ANG_PI) begin
      zb_next = za + ANG_TWO_PI;
    end else begin
      zb_next = za;
    end
  end

  always_comb begin
    nc_next = 1'b0;
    zc_next = zb;
    if (zb > ANG_HALF_PI) begin
      zc_next = zb - ANG_PI;
      nc_next = 1'b1;
    end else if (zb < -ANG_HALF_PI) begin
      zc_next = zb + ANG_PI;
      nc_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) za <= za_next;
    if (rdy_b && va) zb <= zb_next;
    if (rdy_c && vb) begin
      zc <= zc_next;
      nc <= nc_next;
    end
  end

  always_comb begin
    out_valid    = vc;
    out_data.x   = GAIN_INV;
    out_data.y   = '0;
    out_data.z   = zc;
    out_data.neg = nc;
  end

endmodule

### rtl/cdsn_stage.sv
// ----------------------------------------------------------------------------
// cdsn_stage
// one registered cordic rotation with shift SHIFT
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdsn_stage
  import cdsn_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cdsn_rot_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cdsn_rot_t out_data
);

  localparam logic signed [ZW-1:0] ATAN = atan_q28(5'(SHIFT));

  logic                  valid;
  cdsn_rot_t             data, data_next;
  logic signed [XYW-1:0] xs, ys;

  assign in_ready = !valid || out_ready;

  always_comb begin
    xs = in_data.x >>> SHIFT;
    ys = in_data.y >>> SHIFT;
    data_next.neg = in_data.neg;
    // rotate toward z = 0
    if (!in_data.z[ZW-1]) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ATAN;
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data <= data_next;
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### rtl/cdsn_round.sv
// ----------------------------------------------------------------------------
// cdsn_round
// output register: round y to q16, apply fold sign, saturate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdsn_round
  import cdsn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cdsn_rot_t                in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SINE_W-1:0] sine
);

  logic                     valid;
  logic signed [SINE_W-1:0] sine_q;
  logic signed [XYW:0]      biased, rounded, signed_val;
  logic signed [SINE_W-1:0] sine_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    biased  = {in_data.y[XYW-1], in_data.y} + ROUND_BIAS;
    rounded = biased >>> OUT_SHIFT;
    signed_val = in_data.neg ? -rounded : rounded;
    if (signed_val > SINE_MAX) begin
      sine_next = SINE_W'(SINE_MAX);
    end else if (signed_val < -SINE_MAX) begin
      sine_next = SINE_W'(-SINE_MAX);
    end else begin
      sine_next = signed_val[SINE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) sine_q <= sine_next;
  end

  assign out_valid = valid;
  assign sine      = sine_q;

endmodule
